@@ design/chd_pkg.sv @@
// ---------------------------------------------------------------------------
// chd_pkg
// Types shared by the chunked body decoder modules.
// ---------------------------------------------------------------------------
package chd_pkg;

    localparam int COUNT_BITS = 32;

    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_SIZE_LF = 3'd1,
        PH_DATA    = 3'd2,
        PH_DATA_CR = 3'd3,
        PH_DATA_LF = 3'd4,
        PH_ENDED   = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        ST_RUN   = 3'd0,
        ST_OK    = 3'd1,
        ST_BAD   = 3'd2,
        ST_CRLF  = 3'd3,
        ST_TRUNC = 3'd4,
        ST_OVF   = 3'd5
    } t_status;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    typedef struct packed {
        logic       valid;
        t_status    status;
        logic       finished;
        logic       data_valid;
        logic [7:0] data_byte;
    } t_result;

endpackage

@@ design/chd_parser.sv @@
// ---------------------------------------------------------------------------
// chd_parser
// Parse state and per-beat decode of the chunked body.
// ---------------------------------------------------------------------------
module chd_parser
    import chd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_result    o_result
);

    t_phase                  r_phase, n_phase;
    logic [COUNT_BITS-1:0]   r_count, n_count;
    logic                    r_digit_seen, n_digit_seen;
    logic                    r_trail_seen, n_trail_seen;
    logic                    r_in_ext, n_in_ext;

    t_status                 w_end;
    logic                    w_emit;
    logic                    w_is_hex;
    logic [3:0]              w_hex;

    always_comb begin
        w_is_hex = 1'b1;
        w_hex    = 4'd0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            w_hex = 4'(i_byte - 8'h30);
        end else if (i_byte >= 8'h61 && i_byte <= 8'h66) begin
            w_hex = 4'(i_byte - 8'h57);
        end else if (i_byte >= 8'h41 && i_byte <= 8'h46) begin
            w_hex = 4'(i_byte - 8'h37);
        end else begin
            w_is_hex = 1'b0;
        end
    end

    // beat outcome
    always_comb begin
        logic [2:0] status_v;
        status_v = ST_RUN;
        w_emit   = 1'b0;
        unique case (r_phase)
            PH_SIZE: begin
                if (!r_in_ext && i_byte != CH_CR && i_byte != CH_SEMI &&
                    i_byte != CH_SPACE && i_byte != CH_TAB) begin
                    if (!w_is_hex || r_trail_seen) begin
                        status_v = ST_BAD;
                    end else if (r_count[COUNT_BITS-1 -: 4] != 4'd0) begin
                        status_v = ST_OVF;
                    end
                end
            end
            PH_SIZE_LF: begin
                if (i_byte != CH_LF) begin
                    status_v = ST_CRLF;
                end else if (r_count == '0) begin
                    status_v = ST_OK;
                end
            end
            PH_DATA: begin
                w_emit = 1'b1;
            end
            PH_DATA_CR: begin
                if (i_byte != CH_CR) begin
                    status_v = ST_CRLF;
                end
            end
            PH_DATA_LF: begin
                if (i_byte != CH_LF) begin
                    status_v = ST_CRLF;
                end else if (i_last) begin
                    status_v = ST_OK;
                end
            end
            default: begin
                status_v = ST_RUN;
            end
        endcase
        if (status_v == ST_RUN && i_last) begin
            status_v = ST_TRUNC;
        end
        w_end = t_status'(status_v);
    end

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_count      = r_count;
        n_digit_seen = r_digit_seen;
        n_trail_seen = r_trail_seen;
        n_in_ext     = r_in_ext;
        unique case (r_phase)
            PH_SIZE: begin
                if (i_byte == CH_CR) begin
                    n_phase = PH_SIZE_LF;
                end else if (r_in_ext) begin
                    n_in_ext = 1'b1;
                end else if (i_byte == CH_SEMI) begin
                    n_in_ext = 1'b1;
                end else if (i_byte == CH_SPACE || i_byte == CH_TAB) begin
                    if (r_digit_seen) begin
                        n_trail_seen = 1'b1;
                    end
                end else begin
                    n_count      = {r_count[COUNT_BITS-5:0], w_hex};
                    n_digit_seen = 1'b1;
                end
            end
            PH_SIZE_LF: begin
                n_phase = PH_DATA;
            end
            PH_DATA: begin
                n_count = r_count - COUNT_BITS'(1);
                if (r_count == COUNT_BITS'(1)) begin
                    n_phase = PH_DATA_CR;
                end
            end
            PH_DATA_CR: begin
                n_phase = PH_DATA_LF;
            end
            PH_DATA_LF: begin
                n_phase      = PH_SIZE;
                n_count      = '0;
                n_digit_seen = 1'b0;
                n_trail_seen = 1'b0;
                n_in_ext     = 1'b0;
            end
            default: begin
                n_phase = PH_ENDED;
            end
        endcase
        if (w_end != ST_RUN) begin
            n_phase = PH_ENDED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SIZE;
            r_count      <= '0;
            r_digit_seen <= 1'b0;
            r_trail_seen <= 1'b0;
            r_in_ext     <= 1'b0;
        end else if (i_accept && r_phase != PH_ENDED) begin
            r_phase      <= n_phase;
            r_count      <= n_count;
            r_digit_seen <= n_digit_seen;
            r_trail_seen <= n_trail_seen;
            r_in_ext     <= n_in_ext;
        end
    end

    always_comb begin
        o_result.valid      = i_accept && r_phase != PH_ENDED &&
                              (w_emit || w_end != ST_RUN);
        o_result.status     = w_end;
        o_result.finished   = (w_end != ST_RUN);
        o_result.data_valid = w_emit;
        o_result.data_byte  = w_emit ? i_byte : 8'd0;
    end

    a_ended_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_ENDED |=> r_phase == PH_ENDED)
        else $error("left ended phase");
    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_count != '0)
        else $error("data phase with zero count");
    a_no_result_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_ENDED |-> !o_result.valid)
        else $error("result after end");

endmodule

@@ design/chd_out_buf.sv @@
// ---------------------------------------------------------------------------
// chd_out_buf
// Result register with a skid stage toward the master side.
// ---------------------------------------------------------------------------
module chd_out_buf
    import chd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_result i_result,
    output logic    o_can_accept,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    w_take;

    assign w_take       = r_main_valid && i_ready;
    assign o_can_accept = !r_skid_valid;
    assign o_valid      = r_main_valid;
    assign o_result     = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_result.valid;
            end
        end else if (!r_main_valid) begin
            r_main_valid <= i_result.valid;
        end else if (i_result.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && r_skid_valid) begin
            r_main <= r_skid;
        end else if (w_take || !r_main_valid) begin
            r_main <= i_result;
        end else if (i_result.valid) begin
            r_skid <= i_result;
        end
    end

    a_skid_implies_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid holds data with empty main register");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result.valid |-> !r_skid_valid)
        else $error("result pushed into full buffer");
    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_main_valid && !i_ready) |=> r_main_valid)
        else $error("stalled result dropped");

endmodule

@@ design/http_chunked_body_decoder_top.sv @@
// ---------------------------------------------------------------------------
// http_chunked_body_decoder_top
// Decodes an HTTP chunked transfer body into its payload bytes.
// ---------------------------------------------------------------------------
// Slave side: one raw body byte per beat in s_tdata, s_tlast on the final
// byte of the body. Master side: one result beat for each payload byte and
// for the byte at which decoding ends (both may share a beat); bytes of the
// size lines and CRLFs that end nothing produce no beat.
// Throughput is one byte per cycle while s_tready is high: each byte is
// decoded by the parse state update. The result of an accepted byte is
// registered in the output buffer before it reaches the master side.
// The master side has a result register and a skid register, so a stall is
// absorbed for one beat; s_tready drops only once the skid holds a result.
// After the end (ok or error) further bytes are accepted and dropped.
// Reset returns the parser to the start of a size line and empties the
// output buffer.
// ---------------------------------------------------------------------------
module http_chunked_body_decoder_top
    import chd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] byte_in
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_byte
    output logic [4:0] m_tuser    // [0] data_valid, [1] finished, [4:2] status
);

    t_result w_parse;
    t_result w_out;
    logic    w_can_accept;
    logic    w_accept;

    assign s_tready = w_can_accept;
    assign w_accept = s_tvalid && w_can_accept;

    chd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (s_tdata),
        .i_last   (s_tlast),
        .o_result (w_parse)
    );

    chd_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_result     (w_parse),
        .o_can_accept (w_can_accept),
        .o_valid      (m_tvalid),
        .i_ready      (m_tready),
        .o_result     (w_out)
    );

    assign m_tdata = w_out.data_byte;
    assign m_tuser = {w_out.status, w_out.finished, w_out.data_valid};

endmodule

@@ sim/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for http_chunked_body_decoder_top.
// One chunked body is streamed per run, since the decoder stays ended until
// reset: a directed prologue, then random chunks with random size-line
// formatting, then one ending picked at random (ok by zero size, empty line
// or last byte on the closing LF, bad size char, missing CRLF, truncation,
// size overflow), then a few bytes the block must drop. Every accepted byte
// runs through a local decoder model; result beats are checked in order.
// ---------------------------------------------------------------------------
module tb;
    import chd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       dv;
        logic       fin;
        t_status    st;
    } beat_t;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
        logic       chk;    // want holds the typed-in result beat
        beat_t      want;
    } row_t;

    localparam beat_t NO_BEAT    = '{8'h00, 1'b0, 1'b0, ST_RUN};
    localparam int    N_RANDOM   = 950;
    localparam int    IDLE_LIMIT = 500;

    // tab, space, "0c", space, tab, ";x", LF inside extension, CRLF, 12 bytes, CRLF
    localparam row_t DIR_ROWS [0:24] = '{
        '{8'h09, 1'b0, 1'b0, NO_BEAT},
        '{8'h20, 1'b0, 1'b0, NO_BEAT},
        '{8'h30, 1'b0, 1'b0, NO_BEAT},
        '{8'h63, 1'b0, 1'b0, NO_BEAT},
        '{8'h20, 1'b0, 1'b0, NO_BEAT},
        '{8'h09, 1'b0, 1'b0, NO_BEAT},
        '{8'h3B, 1'b0, 1'b0, NO_BEAT},
        '{8'h78, 1'b0, 1'b0, NO_BEAT},
        '{8'h0A, 1'b0, 1'b0, NO_BEAT},
        '{8'h0D, 1'b0, 1'b0, NO_BEAT},
        '{8'h0A, 1'b0, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, ST_RUN}},
        '{8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, ST_RUN}},
        '{8'h0D, 1'b0, 1'b1, '{8'h0D, 1'b1, 1'b0, ST_RUN}},
        '{8'h0A, 1'b0, 1'b1, '{8'h0A, 1'b1, 1'b0, ST_RUN}},
        '{8'h3B, 1'b0, 1'b1, '{8'h3B, 1'b1, 1'b0, ST_RUN}},
        '{8'h20, 1'b0, 1'b1, '{8'h20, 1'b1, 1'b0, ST_RUN}},
        '{8'h80, 1'b0, 1'b1, '{8'h80, 1'b1, 1'b0, ST_RUN}},
        '{8'h7F, 1'b0, 1'b1, '{8'h7F, 1'b1, 1'b0, ST_RUN}},
        '{8'h55, 1'b0, 1'b1, '{8'h55, 1'b1, 1'b0, ST_RUN}},
        '{8'hAA, 1'b0, 1'b1, '{8'hAA, 1'b1, 1'b0, ST_RUN}},
        '{8'h30, 1'b0, 1'b1, '{8'h30, 1'b1, 1'b0, ST_RUN}},
        '{8'h01, 1'b0, 1'b1, '{8'h01, 1'b1, 1'b0, ST_RUN}},
        '{8'h0D, 1'b0, 1'b0, NO_BEAT},
        '{8'h0A, 1'b0, 1'b0, NO_BEAT}
    };

    logic       i_clk;
    logic       i_rst_n  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] byte_in
    logic       s_tlast  = 1'b0;    // last_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] data_byte
    logic [4:0] m_tuser;            // [0] data_valid, [1] finished, [4:2] status

    http_chunked_body_decoder_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    row_t  body_q[$];
    beat_t decoded_q[$];
    int    n_taken   = 0;
    int    n_bad     = 0;
    int    n_dir     = 0;
    int    ending_at = 0;
    logic  calm      = 1'b0;

    // decoder model state
    t_phase                dec_phase     = PH_SIZE;
    logic [COUNT_BITS-1:0] chunk_left    = '0;
    logic                  saw_digit     = 1'b0;
    logic                  saw_trail_ws  = 1'b0;
    logic                  in_ext        = 1'b0;

    function automatic int hex_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
        return -1;
    endfunction

    function automatic void new_size_line();
        dec_phase    = PH_SIZE;
        chunk_left   = '0;
        saw_digit    = 1'b0;
        saw_trail_ws = 1'b0;
        in_ext       = 1'b0;
    endfunction

    // Advances the model by one body byte; returns 1 when a result beat is due.
    function automatic logic decode_byte(input logic [7:0] c, input logic last,
                                         output beat_t r);
        logic    emit;
        t_status st;
        int      hv;
        emit = 1'b0;
        st   = ST_RUN;
        r    = NO_BEAT;
        if (dec_phase == PH_ENDED) return 1'b0;
        case (dec_phase)
            PH_SIZE: begin
                if (in_ext) begin
                    if (c == CH_CR) dec_phase = PH_SIZE_LF;
                end else if (c == CH_CR) begin
                    dec_phase = PH_SIZE_LF;
                end else if (c == CH_SEMI) begin
                    in_ext = 1'b1;
                end else if (c == CH_SPACE || c == CH_TAB) begin
                    if (saw_digit) saw_trail_ws = 1'b1;
                end else begin
                    hv = hex_val(c);
                    if (hv < 0 || saw_trail_ws) begin
                        st = ST_BAD;
                    end else if (chunk_left[COUNT_BITS-1 -: 4] != 4'h0) begin
                        st = ST_OVF;
                    end else begin
                        chunk_left = {chunk_left[COUNT_BITS-5:0], hv[3:0]};
                        saw_digit  = 1'b1;
                    end
                end
            end
            PH_SIZE_LF: begin
                if (c != CH_LF) st = ST_CRLF;
                else if (chunk_left == '0) st = ST_OK;
                else dec_phase = PH_DATA;
            end
            PH_DATA: begin
                emit       = 1'b1;
                chunk_left = chunk_left - 1'b1;
                if (chunk_left == '0) dec_phase = PH_DATA_CR;
            end
            PH_DATA_CR: begin
                if (c != CH_CR) st = ST_CRLF;
                else dec_phase = PH_DATA_LF;
            end
            default: begin
                if (c != CH_LF) begin
                    st = ST_CRLF;
                end else begin
                    new_size_line();
                    if (last) st = ST_OK;
                end
            end
        endcase
        if (st == ST_RUN && last) st = ST_TRUNC;
        if (st != ST_RUN) dec_phase = PH_ENDED;
        if (!emit && st == ST_RUN) return 1'b0;
        r.data = emit ? c : 8'h00;
        r.dv   = emit;
        r.fin  = (st != ST_RUN);
        r.st   = st;
        return 1'b1;
    endfunction

    task automatic flag(input string what, input int unsigned got, input int unsigned want);
        if (n_bad < 40)
            $display("%0t ns  %s: got %0h, expected %0h", $time, what, got, want);
        n_bad++;
    endtask

    // ---- body builder ----
    task automatic push_byte(input logic [7:0] b, input logic last = 1'b0);
        body_q.push_back('{b, last, 1'b0, NO_BEAT});
    endtask

    function automatic logic [7:0] ws_char();
        return ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        if (d < 4'd10) return 8'h30 + d;
        return (($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + d - 8'd10;
    endfunction

    task automatic push_size_digits(input logic [COUNT_BITS-1:0] n);
        int nd;
        int k;
        nd = 1;
        for (k = 1; k < COUNT_BITS / 4; k++)
            if ((n >> (4 * k)) != '0) nd = k + 1;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) push_byte(ws_char());
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) push_byte(8'h30);
        for (k = nd - 1; k >= 0; k--) push_byte(hex_char(n[4*k +: 4]));
    endtask

    task automatic push_size_tail();
        logic [7:0] b;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) push_byte(ws_char());
        if ($urandom_range(0, 9) < 3) begin
            push_byte(CH_SEMI);
            repeat ($urandom_range(0, 5)) begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_CR);
                push_byte(b);
            end
        end
    endtask

    task automatic push_size_line(input logic [COUNT_BITS-1:0] n);
        push_size_digits(n);
        push_size_tail();
        push_byte(CH_CR);
        push_byte(CH_LF);
    endtask

    task automatic push_chunk(input int n);
        push_size_line(COUNT_BITS'(n));
        repeat (n) push_byte(8'($urandom_range(0, 255)));
        push_byte(CH_CR);
        push_byte(CH_LF);
    endtask

    task automatic push_ending();
        logic [7:0] b;
        int         n;
        case ($urandom_range(0, 9))
            0: begin    // zero-size chunk
                push_size_digits('0);
                push_size_tail();
                push_byte(CH_CR);
                push_byte(CH_LF, 1'($urandom_range(0, 1)));
            end
            1: begin    // size line without digits
                push_size_tail();
                push_byte(CH_CR);
                push_byte(CH_LF, 1'($urandom_range(0, 1)));
            end
            2: body_q[body_q.size()-1].last = 1'b1;
            3: begin    // bad size char
                n = $urandom_range(0, 2);
                if (n != 1 || $urandom_range(0, 1) != 0)
                    push_size_digits(COUNT_BITS'($urandom_range(1, 255)));
                if (n == 0) begin
                    do b = 8'($urandom_range(0, 255));
                    while (hex_val(b) >= 0 || b == CH_SPACE || b == CH_TAB ||
                           b == CH_SEMI || b == CH_CR);
                    push_byte(b);
                end else if (n == 1) begin
                    push_byte(CH_LF);
                end else begin
                    push_byte(ws_char());
                    push_byte(hex_char(4'($urandom_range(0, 15))));
                end
            end
            4: begin    // CR without LF in size line
                push_size_digits(COUNT_BITS'($urandom_range(0, 64)));
                push_size_tail();
                push_byte(CH_CR);
                do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
                push_byte(b);
            end
            5: begin    // broken CRLF after data
                n = $urandom_range(1, 8);
                push_size_line(COUNT_BITS'(n));
                repeat (n) push_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) != 0) begin
                    do b = 8'($urandom_range(0, 255)); while (b == CH_CR);
                    push_byte(b);
                end else begin
                    push_byte(CH_CR);
                    do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
                    push_byte(b);
                end
            end
            6: begin    // truncated in size line or before data LF
                if ($urandom_range(0, 1) != 0) begin
                    push_size_digits(COUNT_BITS'($urandom_range(1, 255)));
                end else begin
                    n = $urandom_range(1, 8);
                    push_size_line(COUNT_BITS'(n));
                    repeat (n) push_byte(8'($urandom_range(0, 255)));
                    push_byte(CH_CR);
                end
                body_q[body_q.size()-1].last = 1'b1;
            end
            7: begin    // one digit more than the counter holds
                if ($urandom_range(0, 1) != 0) push_byte(8'h30);
                push_byte(hex_char(4'($urandom_range(1, 15))));
                repeat (COUNT_BITS / 4) push_byte(hex_char(4'($urandom_range(0, 15))));
            end
            8: begin    // largest size, cut off inside the data
                push_size_line('1);
                repeat ($urandom_range(0, 19)) push_byte(8'($urandom_range(0, 255)));
                push_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            default: begin  // final byte is the LF before data
                push_size_line(COUNT_BITS'($urandom_range(1, 255)));
                body_q[body_q.size()-1].last = 1'b1;
            end
        endcase
    endtask

    task automatic build_body();
        int k;
        for (k = 0; k < 25; k++) body_q.push_back(DIR_ROWS[k]);
        n_dir = body_q.size();
        while (body_q.size() < n_dir + N_RANDOM - 30) begin
            k = $urandom_range(0, 19);
            if (k < 15) push_chunk($urandom_range(1, 12));
            else if (k < 19) push_chunk($urandom_range(13, 48));
            else push_chunk($urandom_range(49, 200));
        end
        ending_at = body_q.size();
        push_ending();
        repeat ($urandom_range(2, 9))
            push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        push_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // ---- sender ----
    initial begin : sender
        int i;
        int calm_at;
        int quiet;
        quiet = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        build_body();
        calm_at = body_q.size() * 85 / 100;
        @(posedge i_clk);
        for (i = 0; i < body_q.size(); i++) begin
            if (i == calm_at) calm <= 1'b1;
            if (i == n_dir || i == ending_at) begin
                s_tvalid <= 1'b0;
                @(posedge i_clk);
                while (decoded_q.size() != 0) @(posedge i_clk);
            end else if (!calm && i >= 1) begin
                if (quiet > 0) begin
                    quiet--;
                end else if ($urandom_range(0, 19) == 0) begin
                    quiet = $urandom_range(20, 80);
                end else if ($urandom_range(0, 3) == 0) begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 10)) @(posedge i_clk);
                end
            end
            s_tvalid <= 1'b1;
            s_tdata  <= body_q[i].b;
            s_tlast  <= body_q[i].last;
            @(posedge i_clk);
            while (!s_tready) @(posedge i_clk);
        end
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (n_bad == 0) begin
            $display("** http_chunked_body_decoder_top: PASSED **");
        end else begin
            $display("** http_chunked_body_decoder_top: FAILED **");
        end
        $finish;
    end

    // ---- receiver backpressure ----
    int rdy_left = 0;
    always @(posedge i_clk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else if (rdy_left > 0) begin
            rdy_left <= rdy_left - 1;
        end else if (m_tready) begin
            if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                rdy_left <= $urandom_range(0, 9);
            end else begin
                rdy_left <= $urandom_range(0, 5);
            end
        end else begin
            m_tready <= 1'b1;
            rdy_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(0, 30);
        end
    end

    // ---- result check ----
    always @(posedge i_clk) begin : result_check
        beat_t exp_b;
        beat_t model_b;
        logic  due;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if (decoded_q.size() == 0) begin
                    flag("result beat with nothing expected", {m_tuser, m_tdata}, 0);
                end else begin
                    exp_b = decoded_q.pop_front();
                    if (m_tdata != exp_b.data) flag("data_byte", m_tdata, exp_b.data);
                    if (m_tuser[0] != exp_b.dv) flag("data_valid", m_tuser[0], exp_b.dv);
                    if (m_tuser[1] != exp_b.fin) flag("finished", m_tuser[1], exp_b.fin);
                    if (m_tuser[4:2] != exp_b.st) flag("status", m_tuser[4:2], exp_b.st);
                end
            end
            if (s_tvalid && s_tready) begin
                due = decode_byte(s_tdata, s_tlast, model_b);
                if (body_q[n_taken].chk) decoded_q.push_back(body_q[n_taken].want);
                else if (due) decoded_q.push_back(model_b);
                n_taken++;
            end
        end
    end

    // ---- watchdog ----
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t ns  no beat accepted for %0d cycles", $time, IDLE_LIMIT);
                $display("** http_chunked_body_decoder_top: FAILED **");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

@@ http_chunked_body_decoder_top.f @@
design/chd_pkg.sv
design/chd_parser.sv
design/chd_out_buf.sv
design/http_chunked_body_decoder_top.sv
sim/tb.sv
